[hdl/scld_pkg.sv]
// Shared constants, types and scanner functions for the servo command line decoder.
`timescale 1ns / 1ps
package scld_pkg;

  localparam int BYTE_W        = 8;
  localparam int TICK_W        = 15;
  localparam int ACC_W         = 8;
  localparam int AXES          = 2;
  localparam int LINE_KEEP_DEF = 63;
  localparam int CFG_ADDR_W    = 5;
  localparam int CFG_DATA_W    = 32;

  // Character codes
  localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_X     = 8'h58;
  localparam logic [BYTE_W-1:0] CH_Y     = 8'h59;

  localparam logic [BYTE_W-1:0] AXIS_LETTER [AXES] = '{CH_X, CH_Y};

  localparam logic [ACC_W-1:0] ANGLE_MAX = 8'd180;
  localparam logic [ACC_W-1:0] ANGLE_MID = 8'd90;
  localparam logic [ACC_W-1:0] ACC_SAT   = 8'd255;

  // Reset tick values
  localparam logic [TICK_W-1:0] X_MIN_RST = 15'd950;
  localparam logic [TICK_W-1:0] X_MID_RST = 15'd2025;
  localparam logic [TICK_W-1:0] X_MAX_RST = 15'd3400;
  localparam logic [TICK_W-1:0] Y_MIN_RST = 15'd700;
  localparam logic [TICK_W-1:0] Y_MID_RST = 15'd1700;
  localparam logic [TICK_W-1:0] Y_MAX_RST = 15'd3000;

  // Divide by 90 as halve, then multiply by ceil(2^27 / 45) and shift;
  // exact for halved magnitudes below 2^21.
  localparam int                 PROD_W     = 24;
  localparam int                 HALF_W     = 21;
  localparam int                 RECIP_W    = 22;
  localparam int                 MUL_W      = HALF_W + RECIP_W;
  localparam int                 DIV_SHIFT  = 27;
  localparam logic [RECIP_W-1:0] DIV_RECIP  = 22'd2982617;
  localparam int                 QUOT_W     = MUL_W - DIV_SHIFT;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_AFTER,
    PH_BLANK,
    PH_DIGIT,
    PH_DONE
  } scan_phase_t;

  typedef struct packed {
    scan_phase_t      phase;
    logic             neg;
    logic [ACC_W-1:0] acc;
  } scan_state_t;

  typedef enum logic [2:0] {
    REG_X_MIN = 3'd0,
    REG_X_MID = 3'd1,
    REG_X_MAX = 3'd2,
    REG_Y_MIN = 3'd3,
    REG_Y_MID = 3'd4,
    REG_Y_MAX = 3'd5
  } cfg_reg_t;

  localparam scan_state_t SCAN_IDLE = '{phase: PH_WAIT, neg: 1'b0, acc: '0};

  // One byte through a letter scanner: letter, optional colon, blanks, sign, digits.
  function automatic scan_state_t scan_step(input logic [BYTE_W-1:0] c,
                                            input logic [BYTE_W-1:0] letter,
                                            input scan_state_t s);
    scan_state_t        n;
    scan_phase_t        p;
    logic               done;
    logic               blank;
    logic               digit;
    logic [BYTE_W-1:0]  dval;
    logic [11:0]        v;
    n     = s;
    p     = s.phase;
    done  = 1'b0;
    blank = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    dval  = c - CH_ZERO;
    v     = 12'({4'd0, s.acc}) * 12'd10 + 12'({4'd0, dval});
    if (p == PH_WAIT) begin
      if (c == letter) n.phase = PH_AFTER;
      done = 1'b1;
    end
    if (!done && (p == PH_AFTER)) begin
      if (c == CH_COLON) begin
        n.phase = PH_BLANK;
        done    = 1'b1;
      end else begin
        p = PH_BLANK;
      end
    end
    if (!done && (p == PH_BLANK)) begin
      if (blank) begin
        n.phase = PH_BLANK;
        done    = 1'b1;
      end else if ((c == CH_PLUS) || (c == CH_MINUS)) begin
        n.neg   = (c == CH_MINUS);
        n.phase = PH_DIGIT;
        done    = 1'b1;
      end else begin
        p = PH_DIGIT;
      end
    end
    if (!done && (p == PH_DIGIT)) begin
      if (digit) begin
        n.acc   = (v > 12'({4'd0, ACC_SAT})) ? ACC_SAT : v[ACC_W-1:0];
        n.phase = PH_DIGIT;
      end else begin
        n.phase = PH_DONE;
      end
    end
    return n;
  endfunction

  // Clamp the parsed number to an angle of 0..180.
  function automatic logic [ACC_W-1:0] angle_of(input logic neg, input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] a;
    a = (acc > ANGLE_MAX) ? ANGLE_MAX : acc;
    return neg ? '0 : a;
  endfunction

endpackage

[hdl/scld_ifs.sv]
// Valid/ready channel interfaces for received bytes and decoded servo words.
`timescale 1ns / 1ps
interface scld_in_if;
  import scld_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scld_out_if;
  import scld_pkg::*;
  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] x_pulse;
  logic [TICK_W-1:0] y_pulse;
  logic              x_moved;
  logic              y_moved;
  logic              led_on;
  modport source (output valid, output x_pulse, output y_pulse, output x_moved,
                  output y_moved, output led_on, input ready);
  modport sink   (input valid, input x_pulse, input y_pulse, input x_moved,
                  input y_moved, input led_on, output ready);
endinterface

[hdl/servo_command_line_decoder_unit.sv]
// Servo command line decoder: byte scanner, angle-to-tick mapper and APB tick registers.
// Throughput: one received word per cycle, except while a newline in the input stage waits
// for the angle stage to take it; ordinary bytes finish in the input stage.
// The five-stage path (input, angle, multiply, divide, output) is elastic, so the input
// keeps taking words while a result word waits to be taken, until a newline meets a full pipe.
// Reset (synchronous, rst_n low) empties the pipe, clears the line and restores tick values.
`timescale 1ns / 1ps
module servo_command_line_decoder_unit #(
  parameter int LINE_KEEP = scld_pkg::LINE_KEEP_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  scld_in_if.sink                             in_ch,
  scld_out_if.source                          out_ch,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [scld_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [scld_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [scld_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import scld_pkg::*;

  localparam int CNT_W = $clog2(LINE_KEEP + 1);

  // ---------------------------------------------------------------------------
  // APB tick registers. Writes land on the access cycle; reads are plain muxes.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] x_min_r, x_mid_r, x_max_r;
  logic [TICK_W-1:0] y_min_r, y_mid_r, y_max_r;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= X_MIN_RST;
      x_mid_r <= X_MID_RST;
      x_max_r <= X_MAX_RST;
      y_min_r <= Y_MIN_RST;
      y_mid_r <= Y_MID_RST;
      y_max_r <= Y_MAX_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_X_MIN: x_min_r <= pwdata[TICK_W-1:0];
        REG_X_MID: x_mid_r <= pwdata[TICK_W-1:0];
        REG_X_MAX: x_max_r <= pwdata[TICK_W-1:0];
        REG_Y_MIN: y_min_r <= pwdata[TICK_W-1:0];
        REG_Y_MID: y_mid_r <= pwdata[TICK_W-1:0];
        REG_Y_MAX: y_max_r <= pwdata[TICK_W-1:0];
        default: ;  // drop writes past the last register
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_X_MIN: prdata = CFG_DATA_W'(x_min_r);
      REG_X_MID: prdata = CFG_DATA_W'(x_mid_r);
      REG_X_MAX: prdata = CFG_DATA_W'(x_max_r);
      REG_Y_MIN: prdata = CFG_DATA_W'(y_min_r);
      REG_Y_MID: prdata = CFG_DATA_W'(y_mid_r);
      REG_Y_MAX: prdata = CFG_DATA_W'(y_max_r);
      default:   prdata = '0;
    endcase
  end

  // Per-axis views of the tick registers (axis 0 is X, axis 1 is Y).
  logic [TICK_W-1:0] lo_tk [AXES];
  logic [TICK_W-1:0] md_tk [AXES];
  logic [TICK_W-1:0] hi_tk [AXES];
  assign lo_tk[0] = x_min_r;
  assign md_tk[0] = x_mid_r;
  assign hi_tk[0] = x_max_r;
  assign lo_tk[1] = y_min_r;
  assign md_tk[1] = y_mid_r;
  assign hi_tk[1] = y_max_r;

  // ---------------------------------------------------------------------------
  // Elastic pipeline handshake. Each stage takes a new word when it is empty
  // or its word moves on. Ordinary bytes retire in stage 0 and never wait.
  // ---------------------------------------------------------------------------
  logic              v0_r, v1_r, v2_r, v3_r, v4_r;
  logic              rdy1, rdy2, rdy3, rdy4;
  logic              in_ready;
  logic              is_nl;
  logic              move0;
  logic              pass1;
  logic [BYTE_W-1:0] byte0_r;

  assign rdy4     = !v4_r || out_ch.ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign is_nl    = (byte0_r == CH_NL);
  assign move0    = v0_r && (!is_nl || rdy1);
  assign pass1    = v0_r && is_nl && rdy1;
  assign in_ready = !v0_r || move0;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (in_ready) v0_r <= in_ch.valid;
      if (rdy1)     v1_r <= pass1;
      if (rdy2)     v2_r <= v1_r;
      if (rdy3)     v3_r <= v2_r;
      if (rdy4)     v4_r <= v3_r;
    end
  end

  // Stage 0: hold the received word.
  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) byte0_r <= in_ch.rx_byte;
  end

  // ---------------------------------------------------------------------------
  // Line state: keep count, end-of-text flag, two letter scanners, LED level.
  // A newline clears the line; bytes past the kept length or after a zero byte
  // are dropped.
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] line_cnt_r;
  logic             text_end_r;
  logic             led_r;
  scan_state_t      scan_r   [AXES];
  scan_state_t      scan_nxt [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      scan_nxt[i] = scan_step(byte0_r, AXIS_LETTER[i], scan_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      text_end_r <= 1'b0;
      led_r      <= 1'b0;
      for (int i = 0; i < AXES; i++) scan_r[i] <= SCAN_IDLE;
    end else if (move0) begin
      if (is_nl) begin
        line_cnt_r <= '0;
        text_end_r <= 1'b0;
        led_r      <= !led_r;
        for (int i = 0; i < AXES; i++) scan_r[i] <= SCAN_IDLE;
      end else if (line_cnt_r < CNT_W'(LINE_KEEP)) begin
        line_cnt_r <= line_cnt_r + 1'b1;
        if (!text_end_r) begin
          if (byte0_r == CH_NUL) begin
            text_end_r <= 1'b1;
          end else begin
            for (int i = 0; i < AXES; i++) scan_r[i] <= scan_nxt[i];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: clamp each axis to an angle and note whether its letter was seen.
  // ---------------------------------------------------------------------------
  logic [ACC_W-1:0] ang1_r [AXES];
  logic             mv1_r  [AXES];
  logic             led1_r;

  always_ff @(posedge clk) begin
    if (pass1) begin
      for (int i = 0; i < AXES; i++) begin
        ang1_r[i] <= angle_of(scan_r[i].neg, scan_r[i].acc);
        mv1_r[i]  <= (scan_r[i].phase != PH_WAIT);
      end
      led1_r <= !led_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: pick the segment (below or above 90 degrees) and multiply the
  // offset into it by the segment's tick span.
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod2_r  [AXES];
  logic        [TICK_W-1:0] base2_r  [AXES];
  logic                     mv2_r    [AXES];
  logic                     led2_r;
  logic signed [PROD_W-1:0] prod_nxt [AXES];
  logic        [TICK_W-1:0] base_nxt [AXES];

  always_comb begin
    logic              upper;
    logic [6:0]        off;
    logic signed [15:0] span;
    for (int i = 0; i < AXES; i++) begin
      upper = (ang1_r[i] > ANGLE_MID);
      off   = upper ? 7'(ang1_r[i] - ANGLE_MID) : ang1_r[i][6:0];
      span  = upper ? ($signed({1'b0, hi_tk[i]}) - $signed({1'b0, md_tk[i]}))
                    : ($signed({1'b0, md_tk[i]}) - $signed({1'b0, lo_tk[i]}));
      prod_nxt[i] = $signed({1'b0, off}) * span;
      base_nxt[i] = upper ? md_tk[i] : lo_tk[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      for (int i = 0; i < AXES; i++) begin
        prod2_r[i] <= prod_nxt[i];
        base2_r[i] <= base_nxt[i];
        mv2_r[i]   <= mv1_r[i];
      end
      led2_r <= led1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: divide the magnitude by 90 through a reciprocal multiply.
  // ---------------------------------------------------------------------------
  logic [MUL_W-1:0]  mul3_r  [AXES];
  logic              neg3_r  [AXES];
  logic [TICK_W-1:0] base3_r [AXES];
  logic              mv3_r   [AXES];
  logic              led3_r;
  logic [MUL_W-1:0]  mul_nxt [AXES];

  always_comb begin
    logic [PROD_W-1:0] mag;
    for (int i = 0; i < AXES; i++) begin
      mag        = prod2_r[i][PROD_W-1] ? (PROD_W'(0) - prod2_r[i]) : prod2_r[i];
      mul_nxt[i] = MUL_W'(mag[HALF_W:1]) * MUL_W'(DIV_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      for (int i = 0; i < AXES; i++) begin
        mul3_r[i]  <= mul_nxt[i];
        neg3_r[i]  <= prod2_r[i][PROD_W-1];
        base3_r[i] <= base2_r[i];
        mv3_r[i]   <= mv2_r[i];
      end
      led3_r <= led2_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: apply the sign, add the segment base, and update the held pulse
  // of each axis that moved. Results retire here in line order, so the held pulse always
  // comes from the latest earlier line that moved that axis.
  // ---------------------------------------------------------------------------
  logic [TICK_W-1:0] pulse_now_r [AXES];
  logic [TICK_W-1:0] pulse_nxt   [AXES];
  logic [TICK_W-1:0] pulse4_r    [AXES];
  logic              mv4_r       [AXES];
  logic              led4_r;

  always_comb begin
    logic [QUOT_W:0]   q;
    logic [QUOT_W:0]   sq;
    logic [QUOT_W:0]   t;
    for (int i = 0; i < AXES; i++) begin
      q  = {1'b0, mul3_r[i][MUL_W-1:DIV_SHIFT]};
      sq = neg3_r[i] ? ((QUOT_W + 1)'(0) - q) : q;
      t  = (QUOT_W + 1)'(base3_r[i]) + sq;
      pulse_nxt[i] = mv3_r[i] ? t[TICK_W-1:0] : pulse_now_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_now_r[0] <= X_MID_RST;
      pulse_now_r[1] <= Y_MID_RST;
    end else if (rdy4 && v3_r) begin
      for (int i = 0; i < AXES; i++) pulse_now_r[i] <= pulse_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      for (int i = 0; i < AXES; i++) begin
        pulse4_r[i] <= pulse_nxt[i];
        mv4_r[i]    <= mv3_r[i];
      end
      led4_r <= led3_r;
    end
  end

  assign out_ch.valid   = v4_r;
  assign out_ch.x_pulse = pulse4_r[0];
  assign out_ch.y_pulse = pulse4_r[1];
  assign out_ch.x_moved = mv4_r[0];
  assign out_ch.y_moved = mv4_r[1];
  assign out_ch.led_on  = led4_r;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the servo command line decoder: byte stimulus, line predictor, APB tick setup.
`timescale 1ns / 1ps
module tb_top;
  import scld_pkg::*;

  // Run-wide limits and sizes
  localparam int NUM_TICK_REGS  = 6;
  localparam int REG_SPARE_A    = 6;     // first index past the tick registers
  localparam int REG_SPARE_B    = 7;     // last index that paddr can reach
  localparam int TICK_LIMIT     = 25000;
  localparam int FULL_ANGLE     = 180;
  localparam int HALF_ANGLE     = 90;
  localparam int SETTLE_CYCLES  = 12;    // pause once every owed word is out of the five stages
  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 4;
  localparam int PHASE_BYTES    = 20;

  // One decoded line as it leaves the block
  typedef struct packed {
    logic [TICK_W-1:0] x_pulse;
    logic [TICK_W-1:0] y_pulse;
    logic              x_moved;
    logic              y_moved;
    logic              led_on;
  } servo_word_t;

  // Progress of one letter scanner through the current line
  typedef struct {
    scan_phase_t      phase;
    logic             neg;
    logic [ACC_W-1:0] acc;
  } axis_scan_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  scld_in_if  in_bus ();
  scld_out_if out_bus ();

  servo_command_line_decoder_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Line decoder state mirrored on the testbench side
  logic [TICK_W-1:0] tick_reg [NUM_TICK_REGS];
  int                line_len;
  logic              text_stopped;
  axis_scan_t        x_scan;
  axis_scan_t        y_scan;
  logic [TICK_W-1:0] x_ticks_now;
  logic [TICK_W-1:0] y_ticks_now;
  logic              led_state;

  // Decoded words still owed by the block, oldest first
  servo_word_t pending_words [$];

  // Bytes of the command line being built
  logic [BYTE_W-1:0] line_buf [$];

  // Run bookkeeping
  int bytes_sent       = 0;
  int words_checked    = 0;
  int mismatches       = 0;
  int settings_applied = 0;

  // Sender and receiver pacing
  int burst_left    = 0;
  bit sender_steady = 1'b0;
  int hold_request  = 0;
  int hold_left     = 0;
  int pattern_left  = 0;
  int stall_pct     = 0;
  int idle_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_line();
    line_len     = 0;
    text_stopped = 1'b0;
    x_scan       = '{PH_WAIT, 1'b0, '0};
    y_scan       = '{PH_WAIT, 1'b0, '0};
  endfunction

  function automatic void reset_decoder();
    tick_reg[REG_X_MIN] = X_MIN_RST;
    tick_reg[REG_X_MID] = X_MID_RST;
    tick_reg[REG_X_MAX] = X_MAX_RST;
    tick_reg[REG_Y_MIN] = Y_MIN_RST;
    tick_reg[REG_Y_MID] = Y_MID_RST;
    tick_reg[REG_Y_MAX] = Y_MAX_RST;
    clear_line();
    x_ticks_now = X_MID_RST;
    y_ticks_now = Y_MID_RST;
    led_state   = 1'b0;
  endfunction

  // Advance one scanner by one byte. An early phase can hand the byte on to a
  // later one in the same step: a non-colon after the letter is treated as a
  // blank candidate, a non-blank non-sign as a digit candidate.
  function automatic void step_scanner(input logic [BYTE_W-1:0] c,
                                       input logic [BYTE_W-1:0] letter,
                                       inout axis_scan_t s);
    scan_phase_t cur;
    int          v;
    cur = s.phase;
    if (cur == PH_WAIT) begin
      if (c == letter) s.phase = PH_AFTER;
      return;
    end
    if (cur == PH_AFTER) begin
      if (c == CH_COLON) begin
        s.phase = PH_BLANK;
        return;
      end
      cur = PH_BLANK;
    end
    if (cur == PH_BLANK) begin
      if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
        s.phase = PH_BLANK;
        return;
      end
      if (c == CH_PLUS || c == CH_MINUS) begin
        s.neg   = (c == CH_MINUS);
        s.phase = PH_DIGIT;
        return;
      end
      cur = PH_DIGIT;
    end
    if (cur == PH_DIGIT) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        v       = int'(s.acc) * 10 + int'(c - CH_ZERO);
        s.acc   = (v > int'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
        s.phase = PH_DIGIT;
      end else begin
        s.phase = PH_DONE;
      end
    end
  endfunction

  // Clamp to 0..180, then interpolate on whichever half the angle falls in.
  // Signed int division truncates toward zero, as the block does.
  function automatic logic [TICK_W-1:0] ticks_for(input axis_scan_t s,
                                                  input logic [TICK_W-1:0] lo,
                                                  input logic [TICK_W-1:0] mid,
                                                  input logic [TICK_W-1:0] hi);
    int a;
    int t;
    a = s.neg ? 0 : ((int'(s.acc) > FULL_ANGLE) ? FULL_ANGLE : int'(s.acc));
    if (a <= HALF_ANGLE)
      t = int'(lo) + (a * (int'(mid) - int'(lo))) / HALF_ANGLE;
    else
      t = int'(mid) + ((a - HALF_ANGLE) * (int'(hi) - int'(mid))) / HALF_ANGLE;
    return t[TICK_W-1:0];
  endfunction

  // Feed one accepted byte; a newline closes the line and owes one word.
  function automatic void decode_byte(input logic [BYTE_W-1:0] c);
    servo_word_t w;
    if (c != CH_NL) begin
      if (line_len < LINE_KEEP_DEF) begin
        line_len++;
        if (!text_stopped) begin
          if (c == CH_NUL) begin
            text_stopped = 1'b1;
          end else begin
            step_scanner(c, CH_X, x_scan);
            step_scanner(c, CH_Y, y_scan);
          end
        end
      end
      return;
    end
    led_state = ~led_state;
    w.x_moved = (x_scan.phase != PH_WAIT);
    w.y_moved = (y_scan.phase != PH_WAIT);
    if (w.x_moved)
      x_ticks_now = ticks_for(x_scan, tick_reg[REG_X_MIN], tick_reg[REG_X_MID],
                              tick_reg[REG_X_MAX]);
    if (w.y_moved)
      y_ticks_now = ticks_for(y_scan, tick_reg[REG_Y_MIN], tick_reg[REG_Y_MID],
                              tick_reg[REG_Y_MAX]);
    w.x_pulse = x_ticks_now;
    w.y_pulse = y_ticks_now;
    w.led_on  = led_state;
    pending_words.push_back(w);
    clear_line();
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, long hold-off on request, word checker
  // ---------------------------------------------------------------------------

  // Hold ready low for a counted stretch when a test asks; otherwise stall at a
  // rate that is redrawn after each random-length stretch, zero included.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left--;
    end else if (hold_request > 0) begin
      out_bus.ready <= 1'b0;
      hold_left    = hold_request - 1;
      hold_request = 0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(16, 96);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      pattern_left--;
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Compare every taken word with the oldest one owed
  always @(posedge clk) begin : check_words
    servo_word_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_words.size() == 0) begin
        $display("%0t ns: word with none owed, expected nothing, actual x %0d y %0d",
                 $time, out_bus.x_pulse, out_bus.y_pulse);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        check_field("x_pulse", want.x_pulse, out_bus.x_pulse);
        check_field("y_pulse", want.y_pulse, out_bus.y_pulse);
        check_field("x_moved", want.x_moved, out_bus.x_moved);
        check_field("y_moved", want.y_moved, out_bus.y_moved);
        check_field("led_on", want.led_on, out_bus.led_on);
      end
    end
  end

  // Drop the run when nothing moves on either channel or the APB port for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles, %0d words still owed",
                 $time, idle_cycles, pending_words.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte and hold it until taken. Bursts of random length are
  // separated by random gaps unless the sender is in steady mode.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!sender_steady) gap = $urandom_range(1, 8);
    end
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    bytes_sent++;
    decode_byte(b);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  // Stop offering, wait until every owed word has come, then let the pipe settle
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // APB tick registers
  // ---------------------------------------------------------------------------

  // Setup then access; psel stays high so writes can run back to back
  task automatic write_tick_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(idx * 4);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx < NUM_TICK_REGS) tick_reg[idx] = data[TICK_W-1:0];
  endtask

  task automatic apb_release();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write all six tick registers with the block idle; junk_upper fills the
  // bits above the tick width, which the block must drop
  task automatic set_ticks(input int vals [NUM_TICK_REGS], input bit junk_upper);
    logic [CFG_DATA_W-1:0] data;
    drain_results();
    for (int i = 0; i < NUM_TICK_REGS; i++) begin
      data = CFG_DATA_W'(vals[i]);
      if (junk_upper) data[CFG_DATA_W-1:TICK_W] = (CFG_DATA_W - TICK_W)'($urandom);
      write_tick_reg(i, data);
    end
    apb_release();
    settings_applied++;
  endtask

  // ---------------------------------------------------------------------------
  // Line builders
  // ---------------------------------------------------------------------------

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void add_blank();
    int k;
    k = $urandom_range(0, 5);
    line_buf.push_back((k == 5) ? CH_SPACE : CH_TAB + BYTE_W'(k));
  endfunction

  // Mostly in-range angles, some beyond 180, a few long enough to saturate,
  // and now and then no digits at all
  function automatic void add_number();
    int pick;
    pick = $urandom_range(0, 9);
    if ($urandom_range(0, 6) == 0) add_text("0");
    if (pick < 6)
      add_text($sformatf("%0d", $urandom_range(0, FULL_ANGLE)));
    else if (pick < 8)
      add_text($sformatf("%0d", $urandom_range(FULL_ANGLE + 1, 999)));
    else if (pick == 8)
      add_text($sformatf("%0d", $urandom_range(1000, 99999)));
  endfunction

  // One axis command: letter, maybe doubled, optional colon, blanks, sign, number
  function automatic void add_axis(input logic [BYTE_W-1:0] letter);
    line_buf.push_back(letter);
    if ($urandom_range(0, 19) == 0) line_buf.push_back(letter);
    if ($urandom_range(0, 2) == 0) line_buf.push_back(CH_COLON);
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_blank();
    case ($urandom_range(0, 3))
      0:       line_buf.push_back(CH_PLUS);
      1:       line_buf.push_back(CH_MINUS);
      default: ;
    endcase
    add_number();
    case ($urandom_range(0, 2))
      0:       line_buf.push_back(CH_SPACE);
      1:       add_text(",");
      default: ;
    endcase
  endfunction

  // Four in five lines are well formed with random content; the rest are noise
  // over the full byte range. Every line ends in a newline.
  function automatic void add_random_command();
    logic [BYTE_W-1:0] b;
    if ($urandom_range(0, 99) >= 80) begin
      repeat ($urandom_range(0, 12)) begin
        b = BYTE_W'($urandom_range(0, 255));
        line_buf.push_back((b == CH_NL) ? CH_SPACE : b);
      end
      if ($urandom_range(0, 1)) begin
        line_buf.push_back($urandom_range(0, 1) ? CH_X : CH_Y);
        repeat ($urandom_range(0, 3)) line_buf.push_back(BYTE_W'($urandom_range(32, 126)));
      end
    end else begin
      // lowercase chatter ahead of the commands
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) line_buf.push_back(BYTE_W'($urandom_range(97, 122)));
      case ($urandom_range(0, 4))
        0:       add_axis(CH_X);
        1:       add_axis(CH_Y);
        2:       begin add_axis(CH_X); add_axis(CH_Y); end
        3:       begin add_axis(CH_Y); add_axis(CH_X); end
        default: add_text("go");
      endcase
      if ($urandom_range(0, 9) == 0) begin
        line_buf.push_back(CH_NUL);
        add_axis($urandom_range(0, 1) ? CH_X : CH_Y);
      end
      if ($urandom_range(0, 19) == 0) begin
        while (line_buf.size() < LINE_KEEP_DEF + 3) add_text("a");
        add_axis(CH_X);
      end
    end
    line_buf.push_back(CH_NL);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset ticks: empty line, colon with minus, plus with overrange number,
  // letter with no number, stray 0xFF, zero byte ending the text, doubled letter
  task automatic test_directed_cases();
    add_text("\n");
    add_text("X:-5Y+200\n");
    add_text("YX\t");
    line_buf.push_back(8'hFF);
    line_buf.push_back(CH_NUL);
    add_text("X9\n");
    add_text("X7X9\n");
    send_line();
  endtask

  // Only the first 63 bytes count: digits past the cut and a letter in the
  // last kept byte are both exercised
  task automatic test_long_line();
    repeat (LINE_KEEP_DEF - 3) add_text("a");
    add_text("X456Y9\n");
    repeat (LINE_KEEP_DEF - 1) add_text("b");
    add_text("Y77\n");
    send_line();
  endtask

  // Flat, maxed and inverted tick tables, then back to reset values; spare
  // register indexes must leave everything alone
  task automatic test_tick_extremes();
    int tick_sets [5][NUM_TICK_REGS];
    int angles [6][2];
    tick_sets[0] = '{0, 0, 0, 0, 0, 0};
    tick_sets[1] = '{TICK_LIMIT, TICK_LIMIT, TICK_LIMIT, TICK_LIMIT, TICK_LIMIT, TICK_LIMIT};
    tick_sets[2] = '{TICK_LIMIT, 0, TICK_LIMIT, 0, TICK_LIMIT, 0};
    tick_sets[3] = '{0, 12345, TICK_LIMIT, TICK_LIMIT, 12345, 0};
    tick_sets[4] = '{X_MIN_RST, X_MID_RST, X_MAX_RST, Y_MIN_RST, Y_MID_RST, Y_MAX_RST};
    angles = '{'{0, 180}, '{45, 135}, '{90, 91}, '{179, 1}, '{89, 255}, '{1, 89}};
    foreach (tick_sets[s]) begin
      set_ticks(tick_sets[s], 1'b0);
      if (s == 2) begin
        write_tick_reg(REG_SPARE_A, 32'h0000_1234);
        write_tick_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        apb_release();
      end
      foreach (angles[a]) add_text($sformatf("X%0d Y%0d\n", angles[a][0], angles[a][1]));
      send_line();
    end
  endtask

  // Hold the output off while the sender keeps pushing, so the pipe fills and
  // the input stalls
  task automatic test_output_holdoff();
    hold_request  = HOLDOFF_CYCLES;
    sender_steady = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 3) == 0)
        add_text("\n");
      else
        add_text($sformatf("X%0dY%0d\n", $urandom_range(0, FULL_ANGLE),
                           $urandom_range(0, FULL_ANGLE)));
      send_line();
    end
    sender_steady = 1'b0;
    drain_results();
  endtask

  // Pause the sender until every owed word is back, a few times over
  task automatic test_drain_pauses();
    repeat (4) begin
      repeat (2) begin
        add_random_command();
        send_line();
      end
      drain_results();
    end
  endtask

  // Random lines under random tick tables, with steady and bursty stretches
  task automatic test_random_lines();
    int vals [NUM_TICK_REGS];
    int target;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (vals[i]) vals[i] = $urandom_range(0, TICK_LIMIT);
      set_ticks(vals, p[0]);
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 3) == 0) sender_steady = ~sender_steady;
        add_random_command();
        send_line();
      end
    end
    sender_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.rx_byte = '0;
    out_bus.ready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    reset_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_long_line();
    test_tick_extremes();
    test_output_holdoff();
    test_drain_pauses();
    test_random_lines();
    drain_results();

    $display("Run covered %0d received bytes and %0d decoded lines over %0d tick tables,",
             bytes_sent, words_checked, settings_applied);
    $display("including long lines, zero bytes, saturation, output hold-off and drain pauses.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
